// File: rtl/box_blur_3x3_clipped_core_assert.svh
// Assertion helpers for the checker file.
`ifndef BOX_BLUR_3X3_CLIPPED_CORE_ASSERT_SVH
`define BOX_BLUR_3X3_CLIPPED_CORE_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BB3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bb3_pkg.sv
package bb3_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int OROW_W = 12;
  localparam int OCOL_W = 10;
  localparam int SUM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int REC_SH = 18;
  localparam int REC_W  = REC_SH + 1;
  localparam int PRD_W  = SUM_W + REC_W;
  localparam int CELLS  = 9;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [FW_W-1:0] FW_RST = 11'd1024;
  localparam logic [FH_W-1:0] FH_RST = 13'd768;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // cell index = col*3 + row, col 0 oldest, row 0 top
  typedef logic [CELLS-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             start;
    logic [CELLS-1:0] mask;
  } avg_req_t;

  // ceil(2^18 / n)
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [REC_W-1:0] r;
    case (n)
      4'd2:    r = 19'd131072;
      4'd3:    r = 19'd87382;
      4'd4:    r = 19'd65536;
      4'd5:    r = 19'd52429;
      4'd6:    r = 19'd43691;
      4'd7:    r = 19'd37450;
      4'd8:    r = 19'd32768;
      4'd9:    r = 19'd29128;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/box_blur_3x3_clipped_core.sv
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_blue, in_green, in_red
// out      | out_valid / out_stall| out_blue, out_green, out_red, out_row, out_col,
//          |                      | out_run_last
// cfg      | APB psel/penable     | paddr, pwdata, prdata (frame_width @0, frame_height @4)
//
// An input word raises in_stall until its results are out: two line-store
// reads on the single read port of the RAM fetch the rows above, then the
// 3x3 window shifts. Each result passes through sum, reciprocal multiply and
// output load, plus any out_stall; up to 4 results per input on the last row.
// Synchronous active-low reset; the line store is not cleared.
// A config write restarts the frame at row 0, column 0.
module box_blur_3x3_clipped_core #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bb3_pkg::CH_W-1:0]   in_blue,
  input  logic [bb3_pkg::CH_W-1:0]   in_green,
  input  logic [bb3_pkg::CH_W-1:0]   in_red,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bb3_pkg::CH_W-1:0]   out_blue,
  output logic [bb3_pkg::CH_W-1:0]   out_green,
  output logic [bb3_pkg::CH_W-1:0]   out_red,
  output logic [bb3_pkg::OROW_W-1:0] out_row,
  output logic [bb3_pkg::OCOL_W-1:0] out_col,
  output logic                       out_run_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CW1   = COL_W + 1;
  localparam int RW1   = ROW_W + 1;
  localparam int DEPTH = 3 * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_RD2, S_LOAD, S_SUM, S_WAIT, S_OUT} state_t;

  state_t                      state_r;
  logic [bb3_pkg::FW_W-1:0]    fw_r;
  logic [bb3_pkg::FH_W-1:0]    fh_r;
  logic [CW1-1:0]              w_eff;
  logic [RW1-1:0]              h_eff;
  logic [COL_W-1:0]            col_r, cur_c_r;
  logic [ROW_W-1:0]            row_r, cur_r_r;
  logic [1:0]                  slot_r;
  logic [1:0]                  slot_mid, slot_top;
  logic                        last_col, last_row, accept, cfg_wr;
  logic [AW-1:0]               waddr, raddr, top_addr_r;
  logic [bb3_pkg::PIX_W-1:0]   pix_r, mid_r, rdata;
  bb3_pkg::win_t               win_r;
  logic                        c_ge1_r, c_ge2_r, r_ge1_r, r_ge2_r;
  logic [3:0]                  pend_r, pend_nxt, pend_clr;
  logic [1:0]                  sel;
  logic [2:0]                  colm, rowm;
  bb3_pkg::avg_req_t           req;
  logic                        avg_done;
  logic [bb3_pkg::CH_W-1:0]    avg_b, avg_g, avg_r;
  logic                        ov_r, last_r;
  logic [bb3_pkg::CH_W-1:0]    ob_r, og_r, or_r;
  logic [bb3_pkg::OROW_W-1:0]  orow_r;
  logic [bb3_pkg::OCOL_W-1:0]  ocol_r;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = CW1'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(fw_r);
    end
    if (fh_r == '0) begin
      h_eff = RW1'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      h_eff = RW1'(MAX_HEIGHT);
    end else begin
      h_eff = RW1'(fh_r);
    end
  end

  assign last_col = (CW1'(col_r) + CW1'(1)) == w_eff;
  assign last_row = (RW1'(row_r) + RW1'(1)) == h_eff;
  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == bb3_pkg::REG_HEIGHT) ? 32'(fh_r) : 32'(fw_r);

  assign slot_mid = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
  assign slot_top = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
  assign waddr    = AW'(AW'(slot_r) * AW'(MAX_WIDTH)) + AW'(col_r);
  assign raddr    = (state_r == S_IDLE) ?
                    AW'(AW'(slot_mid) * AW'(MAX_WIDTH)) + AW'(col_r) : top_addr_r;

  bb3_ram #(.WIDTH(bb3_pkg::PIX_W), .DEPTH(DEPTH)) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata ({in_red, in_green, in_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // results in order: (R-1,c-1) (R-1,c) (R,c-1) (R,c)
  always_comb begin
    pend_nxt[0] = (row_r != '0) && (col_r != '0);
    pend_nxt[1] = (row_r != '0) && last_col;
    pend_nxt[2] = last_row && (col_r != '0);
    pend_nxt[3] = last_row && last_col;
  end

  always_comb begin
    if (pend_r[0]) begin
      sel = 2'd0;
    end else if (pend_r[1]) begin
      sel = 2'd1;
    end else if (pend_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    pend_clr = pend_r & (pend_r - 4'd1);
    colm = sel[0] ? {1'b1, c_ge1_r, 1'b0} : {1'b1, 1'b1, c_ge2_r};
    rowm = sel[1] ? {1'b1, r_ge1_r, 1'b0} : {1'b1, 1'b1, r_ge2_r};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        req.mask[i*3+j] = colm[i] && rowm[j];
      end
    end
    req.start = (state_r == S_SUM);
  end

  bb3_avg u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .win   (win_r),
    .done  (avg_done),
    .blue  (avg_b),
    .green (avg_g),
    .red   (avg_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fw_r    <= bb3_pkg::FW_RST;
      fh_r    <= bb3_pkg::FH_RST;
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == bb3_pkg::REG_WIDTH) begin
          fw_r <= pwdata[bb3_pkg::FW_W-1:0];
        end else begin
          fh_r <= pwdata[bb3_pkg::FH_W-1:0];
        end
        col_r  <= '0;
        row_r  <= '0;
        slot_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pend_r <= pend_nxt;
            if (last_col) begin
              col_r <= '0;
              if (last_row) begin
                row_r  <= '0;
                slot_r <= '0;
              end else begin
                row_r  <= row_r + ROW_W'(1);
                slot_r <= slot_top;
              end
            end else begin
              col_r <= col_r + COL_W'(1);
            end
            state_r <= S_RD2;
          end
        end
        S_RD2:  state_r <= S_LOAD;
        S_LOAD: state_r <= (pend_r != '0) ? S_SUM : S_IDLE;
        S_SUM:  state_r <= S_WAIT;
        S_WAIT: begin
          if (avg_done) begin
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            ov_r    <= 1'b0;
            pend_r  <= pend_clr;
            state_r <= (pend_clr != '0) ? S_SUM : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    if (accept) begin
      cur_c_r    <= col_r;
      cur_r_r    <= row_r;
      pix_r      <= {in_red, in_green, in_blue};
      top_addr_r <= AW'(AW'(slot_top) * AW'(MAX_WIDTH)) + AW'(col_r);
      c_ge1_r    <= (col_r != '0);
      c_ge2_r    <= (col_r > COL_W'(1));
      r_ge1_r    <= (row_r != '0);
      r_ge2_r    <= (row_r > ROW_W'(1));
    end
    if (state_r == S_RD2) begin
      mid_r <= rdata;
    end
    if (state_r == S_LOAD) begin
      win_r[2:0] <= win_r[5:3];
      win_r[5:3] <= win_r[8:6];
      win_r[6]   <= rdata;
      win_r[7]   <= mid_r;
      win_r[8]   <= pix_r;
    end
    if (state_r == S_SUM) begin
      orow_r <= sel[1] ? bb3_pkg::OROW_W'(cur_r_r)
                       : bb3_pkg::OROW_W'(cur_r_r - ROW_W'(1));
      ocol_r <= sel[0] ? bb3_pkg::OCOL_W'(cur_c_r)
                       : bb3_pkg::OCOL_W'(cur_c_r - COL_W'(1));
      last_r <= (pend_clr == '0);
    end
    if (state_r == S_WAIT && avg_done) begin
      ob_r <= avg_b;
      og_r <= avg_g;
      or_r <= avg_r;
    end
  end

  assign out_valid    = ov_r;
  assign out_blue     = ob_r;
  assign out_green    = og_r;
  assign out_red      = or_r;
  assign out_row      = orow_r;
  assign out_col      = ocol_r;
  assign out_run_last = last_r;

endmodule

// File: rtl/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 3072,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bb3_avg.sv
module bb3_avg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bb3_pkg::avg_req_t       req,
  input  bb3_pkg::win_t           win,
  output logic                    done,
  output logic [bb3_pkg::CH_W-1:0] blue,
  output logic [bb3_pkg::CH_W-1:0] green,
  output logic [bb3_pkg::CH_W-1:0] red
);

  logic [bb3_pkg::SUM_W-1:0] sb_nxt, sg_nxt, sr_nxt;
  logic [bb3_pkg::SUM_W-1:0] sb_r, sg_r, sr_r;
  logic [bb3_pkg::CNT_W-1:0] n_r;
  logic                      s1_v_r, done_r;
  logic [bb3_pkg::REC_W-1:0] rec;
  logic [bb3_pkg::SUM_W-1:0] half;
  logic [bb3_pkg::PRD_W-1:0] pb, pg, pr;
  logic [bb3_pkg::CH_W-1:0]  b_r, g_r, r_r;

  always_comb begin
    sb_nxt = '0;
    sg_nxt = '0;
    sr_nxt = '0;
    for (int i = 0; i < bb3_pkg::CELLS; i++) begin
      if (req.mask[i]) begin
        sb_nxt = sb_nxt + bb3_pkg::SUM_W'(win[i][7:0]);
        sg_nxt = sg_nxt + bb3_pkg::SUM_W'(win[i][15:8]);
        sr_nxt = sr_nxt + bb3_pkg::SUM_W'(win[i][23:16]);
      end
    end
  end

  assign rec  = bb3_pkg::recip(n_r);
  assign half = bb3_pkg::SUM_W'(n_r >> 1);
  assign pb   = bb3_pkg::PRD_W'(sb_r + half) * bb3_pkg::PRD_W'(rec);
  assign pg   = bb3_pkg::PRD_W'(sg_r + half) * bb3_pkg::PRD_W'(rec);
  assign pr   = bb3_pkg::PRD_W'(sr_r + half) * bb3_pkg::PRD_W'(rec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= req.start;
      done_r <= s1_v_r;
    end
    if (req.start) begin
      sb_r <= sb_nxt;
      sg_r <= sg_nxt;
      sr_r <= sr_nxt;
      n_r  <= bb3_pkg::CNT_W'($countones(req.mask));
    end
    if (s1_v_r) begin
      b_r <= pb[bb3_pkg::REC_SH +: bb3_pkg::CH_W];
      g_r <= pg[bb3_pkg::REC_SH +: bb3_pkg::CH_W];
      r_r <= pr[bb3_pkg::REC_SH +: bb3_pkg::CH_W];
    end
  end

  assign done  = done_r;
  assign blue  = b_r;
  assign green = g_r;
  assign red   = r_r;

endmodule

// File: rtl/bb3_checker.sv
`include "box_blur_3x3_clipped_core_assert.svh"

module bb3_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bb3_pkg::CH_W-1:0]   out_blue,
  input logic [bb3_pkg::CH_W-1:0]   out_green,
  input logic [bb3_pkg::CH_W-1:0]   out_red,
  input logic [bb3_pkg::OROW_W-1:0] out_row,
  input logic [bb3_pkg::OCOL_W-1:0] out_col,
  input logic                       out_run_last,
  input logic                       psel,
  input logic                       penable,
  input logic                       pready
);

  `BB3_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable({out_blue, out_green, out_red, out_row, out_col, out_run_last}), "stalled output word changed")
  `BB3_ASSERT(a_in_busy, in_valid && !in_stall |=> in_stall, "input taken while previous word in flight")
  `BB3_ASSERT(a_last_idle, out_valid && !out_stall && out_run_last |=> !out_valid, "result after last of run")
  `BB3_ASSERT(a_out_blocks_in, out_valid |-> in_stall, "input open while result pending")
  `BB3_ASSERT_ALWAYS(a_pready, psel && penable |-> pready, "APB access without pready")

endmodule

bind box_blur_3x3_clipped_core bb3_checker u_bb3_checker (.*);
